// ===== hdl/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted array priority queue package
// Shared constants, status codes and the control bundle that drives the cells.
// ----------------------------------------------------------------------------
package sapq_pkg;

  // Number of cells in the chain, and so the number of values the queue holds.
  localparam int CAPACITY = 128;

  // Width of a stored value.
  localparam int DATA_W = 32;

  // The entry count must be able to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Width of the occupancy field on the result channel.
  localparam int OCC_W = 8;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } sapq_mode_e;

  typedef enum logic [1:0] {
    STATUS_PUSHED    = 2'd0,
    STATUS_POPPED    = 2'd1,
    STATUS_POP_EMPTY = 2'd2,
    STATUS_PUSH_FULL = 2'd3
  } sapq_status_e;

  // Broadcast control for every cell in the chain for the current cycle.
  typedef struct packed {
    logic push_en;  // insert the broadcast value at its sorted place
    logic pop_en;   // move every entry one place toward the head
  } sapq_ctrl_t;

endpackage

// ===== hdl/sapq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted array priority queue cell
// One slot of the sorted chain: compares the broadcast value with its own entry
// and either keeps it, takes the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module sapq_cell
  import sapq_pkg::*;
(
  input  logic                     clk_i,
  input  sapq_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  input  logic                     occupied_i,
  input  logic                     left_keep_i,
  input  logic signed [DATA_W-1:0] left_value_i,
  input  logic signed [DATA_W-1:0] right_value_i,
  output logic                     keep_o,
  output logic signed [DATA_W-1:0] value_o
);

  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] value_d;

  // An occupied entry that is not greater than the new value stays in place,
  // which keeps equal values in arrival order.
  assign keep_o = occupied_i && (value_q <= push_value_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.pop_en) begin
      value_d = right_value_i;
    end else if (ctrl_i.push_en && !keep_o) begin
      // The first cell that does not keep its entry takes the new value; the
      // cells behind it shift one place toward the tail.
      if (left_keep_i) begin
        value_d = push_value_i;
      end else begin
        value_d = left_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== hdl/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted array priority queue
// Min-priority queue of signed 32-bit values held in ascending order in a
// chain of compare-and-shift cells; push inserts, pop removes the smallest.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ----------------------------------------
//   input     in_valid_i / in_ready_o   mode_i, push_value_i
//   result    out_valid_o / out_ready_i status_o, popped_value_o, occupancy_o
//
// Every input beat updates the whole chain in the cycle it is accepted, and its
// result beat is shown from the output register in the next cycle. One input
// beat is taken per cycle as long as the result side takes each result as it
// appears; the single output register sets that figure.
// While a result waits, a new input beat is taken only in the cycle in which
// the waiting result is taken.
// Reset clears the entry count and the output valid flag; the stored values need
// no reset, because no cell beyond the count is ever read.
//
// Each cell compares its entry with the broadcast push value. The first cell
// whose entry is greater than the value, or which is empty, takes the value,
// and every cell behind it takes its left neighbor's entry. A pop makes every
// cell take its right neighbor's entry and returns the head cell's entry. A
// push into a full chain and a pop from an empty one leave the chain unchanged.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue
  import sapq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     mode_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] popped_value_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  logic                     in_beat;
  logic                     is_push;
  logic                     is_full;
  logic                     is_empty;
  sapq_ctrl_t               ctrl;

  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;

  logic                     out_valid_q;
  logic                     out_valid_d;
  sapq_status_e             status_q;
  sapq_status_e             status_d;
  logic signed [DATA_W-1:0] popped_q;
  logic signed [DATA_W-1:0] popped_d;
  logic [CNT_W-1:0]         occ_q;

  // Extended count so that the low bits of the occupancy field can be taken at
  // any capacity, wider or narrower than the field.
  logic [CNT_W+OCC_W-1:0]   occ_ext;

  logic [CAPACITY-1:0]      occupied;
  logic [CAPACITY-1:0]      keep;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];

  // A new beat is taken when the output register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_beat    = in_valid_i && in_ready_o;

  assign is_push  = (sapq_mode_e'(mode_i) == MODE_PUSH);
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  assign ctrl.push_en = in_beat && is_push && !is_full;
  assign ctrl.pop_en  = in_beat && !is_push && !is_empty;

  // Occupancy flags of the cells, derived from the entry count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_occ
    assign occupied[i] = (count_q > CNT_W'(i));
  end

  // The chain of cells. The head cell sees a keeping neighbor on its left, so
  // it takes the new value whenever it does not keep its own entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_keep;
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_value = push_value_i;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    sapq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .push_value_i  (push_value_i),
      .occupied_i    (occupied[i]),
      .left_keep_i   (left_keep),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .keep_o        (keep[i]),
      .value_o       (cell_value[i])
    );
  end

  // Entry count and the result of the beat being accepted.
  always_comb begin
    count_d     = count_q;
    status_d    = status_q;
    popped_d    = popped_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_beat) begin
      out_valid_d = 1'b1;
      popped_d    = '0;
      if (is_push) begin
        if (is_full) begin
          status_d = STATUS_PUSH_FULL;
        end else begin
          status_d = STATUS_PUSHED;
          count_d  = count_q + CNT_W'(1);
        end
      end else begin
        if (is_empty) begin
          status_d = STATUS_POP_EMPTY;
        end else begin
          status_d = STATUS_POPPED;
          popped_d = cell_value[0];
          count_d  = count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: loaded only with a beat, so it holds while stalled.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      status_q <= status_d;
      popped_q <= popped_d;
      occ_q    <= count_d;
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, occ_q};

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign occupancy_o    = occ_ext[OCC_W-1:0];

endmodule

// ===== hdl/sapq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted array priority queue checker
// Port-level assertions on the queue's handshakes and result fields.
// ----------------------------------------------------------------------------
module sapq_checker
  import sapq_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [1:0]               status_o,
  input logic signed [DATA_W-1:0] popped_value_o,
  input logic [OCC_W-1:0]         occupancy_o
);

  // Every accepted input beat shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("no result after an accepted input beat");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(popped_value_o)
       && $stable(occupancy_o)))
    else $error("result changed while stalled");

  // Input is refused only while a result waits and is not taken.
  a_ready_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input refused without a stalled result");

  // A pop on an empty queue leaves it empty.
  a_empty_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_POP_EMPTY)) |-> (occupancy_o == '0))
    else $error("pop on empty reported a nonzero occupancy");

  // Only a successful pop carries a value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_POPPED)) |-> (popped_value_o == '0))
    else $error("nonzero value without a successful pop");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (.*);
